>>> src/shc_pkg.sv
`timescale 1ns / 1ps
package shc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_THREE_DIM = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEWTON    = 8'd1;

    localparam int EXP_W   = 14;
    localparam int LATENCY = 74;

    localparam logic [31:0] C3D_SIG = 32'd3364422841;
    localparam logic [31:0] C2D_SIG = 32'd2563369783;
    localparam logic signed [EXP_W-1:0] C_EXP = -14'sd27;
    localparam logic signed [EXP_W-1:0] E_Q16 = -14'sd16;
    localparam logic signed [EXP_W-1:0] E_Q32 = -14'sd32;

    typedef struct packed {
        logic [31:0]             m;
        logic signed [EXP_W-1:0] e;
    } mf_t;

    typedef struct packed {
        logic in_cut;
        logic zero;
        logic neg;
        logic upd;
    } ctl_t;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic mf_t mf_from(input logic [63:0] v, input logic [6:0] lz,
                                    input logic signed [EXP_W-1:0] base);
        logic [63:0] sh;
        mf_t         r;
        sh = v << lz;
        r.m = sh[63:32];
        r.e = base + EXP_W'(32) - EXP_W'(lz);
        return r;
    endfunction

    function automatic mf_t mf_mul(input mf_t a, input mf_t b);
        logic [63:0] p;
        mf_t         r;
        p = 64'(a.m) * 64'(b.m);
        r.m = p[63] ? p[63:32] : p[62:31];
        r.e = a.e + b.e + (p[63] ? EXP_W'(32) : EXP_W'(31));
        return r;
    endfunction

    function automatic mf_t mf_divn(input logic [32:0] q, input logic signed [EXP_W-1:0] e);
        mf_t r;
        r.m = q[32] ? q[32:1] : q[31:0];
        r.e = q[32] ? e + EXP_W'(1) : e;
        return r;
    endfunction

endpackage

>>> src/sph_heat_conduction_pair.sv
`timescale 1ns / 1ps
// SPH heat conduction for one neighbor pair, Lucy kernel, signed Q16.16.
// Command channel: an item is taken at a clock edge with start high and busy
// low. busy is high only during and right after reset, so one item can be
// taken every cycle.
// Result channel: done marks delta_energy, within_cutoff and update_j for
// exactly one cycle, in item order. The receiver cannot stall; there is no
// back pressure anywhere.
// Latency is set by the chain of the 32-step square root, the kernel products
// and the 33-step divider for the kernel weight, all pipelined one step per
// stage; throughput is one item per cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
// Index 0 selects the 3D kernel (bit 0), index 1 the newton mode (bit 0);
// other indexes are dropped. Write it only while no item is in flight.
// Reset clears all valid bits (no result comes out of items in flight),
// selects the 3D kernel and clears newton mode.
module sph_heat_conduction_pair (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            del_x,
    input  logic signed [31:0]            del_y,
    input  logic signed [31:0]            del_z,
    input  logic [30:0]                   mass_i,
    input  logic [30:0]                   mass_j,
    input  logic [30:0]                   density_i,
    input  logic [30:0]                   density_j,
    input  logic signed [31:0]            energy_i,
    input  logic signed [31:0]            energy_j,
    input  logic [30:0]                   smoothing_length,
    input  logic signed [31:0]            diffusion_coefficient,
    input  logic                          j_is_local,
    output logic                          done,
    output logic signed [31:0]            delta_energy,
    output logic                          within_cutoff,
    output logic                          update_j
);
    import shc_pkg::*;

    logic three_dim_reg;
    logic newton_reg;
    logic busy_reg;
    logic vld_reg [LATENCY];

    // stage 1
    logic [31:0] ax, ay, az, adc;
    logic signed [32:0] de;
    logic [32:0] ade;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    logic [61:0] hsq_reg, pm_reg, pr_reg;
    logic [31:0] sm_reg, sr_reg, adc_reg;
    logic [32:0] ade_reg;
    logic [30:0] h1_reg;
    logic        zf1_reg, neg1_reg, upd1_reg;

    // stage 2
    logic [63:0] rsq2_reg;
    logic        within2_reg, zf2_reg, neg2_reg, upd2_reg;
    logic [61:0] pm2_reg, pr2_reg;
    logic [31:0] sm2_reg, sr2_reg, adc2_reg;
    logic [32:0] ade2_reg;
    logic [30:0] h2_reg;
    logic [6:0]  lzpm_reg, lzpr_reg, lzsm_reg, lzsr_reg, lzdc_reg, lzde_reg, lzh_reg;
    logic [63:0] rsq_sum;

    // stage 3
    logic [63:0] rsq3_reg;
    logic [30:0] h3_reg;
    mf_t         mnum3_reg, mden3_reg, dnum3_reg, dden3_reg, dcf3_reg, def3_reg, hf3_reg;
    ctl_t        ctl3_reg;

    // root and kernel
    logic [63:0] root_x_reg [32];
    logic [63:0] root_r_reg [32];
    logic [30:0] hdly_reg [32];
    logic [30:0] dist_d;
    logic [30:0] d36_reg;
    logic [6:0]  lzd36_reg;
    mf_t         df37_reg, df38_reg, t38_reg, t39_reg, cst;
    mf_t         hk_reg [6];
    mf_t         hfd_reg [5];
    mf_t         hkd_reg [30];

    // factor chain
    logic [32:0] qm, qd, qw;
    logic signed [EXP_W-1:0] emd_reg [33];
    logic signed [EXP_W-1:0] edd_reg [33];
    logic signed [EXP_W-1:0] ewd_reg [33];
    mf_t         dcfd_reg [34];
    mf_t         defd_reg [35];
    mf_t         vd_reg [33];
    mf_t         v37_reg, v38_reg, v39_reg, v73_reg;
    ctl_t        ctld_reg [70];

    // output
    logic signed [EXP_W:0] s_exp, s_neg;
    logic [32:0] mag;
    logic [31:0] res;
    logic signed [31:0] delta_energy_reg;
    logic        within_cutoff_reg, update_j_reg;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign done      = vld_reg[LATENCY-1];
    assign delta_energy  = delta_energy_reg;
    assign within_cutoff = within_cutoff_reg;
    assign update_j      = update_j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_dim_reg <= 1'b1;
            newton_reg    <= 1'b0;
            busy_reg      <= 1'b1;
            for (int i = 0; i < LATENCY; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THREE_DIM: three_dim_reg <= cfg_data[0];
                    REG_NEWTON:    newton_reg    <= cfg_data[0];
                    default:       ;
                endcase
            end
            vld_reg[0] <= start && !busy_reg;
            for (int i = 1; i < LATENCY; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: magnitudes and products
    always_comb
    begin
        ax  = del_x[31] ? (~del_x + 32'd1) : del_x;
        ay  = del_y[31] ? (~del_y + 32'd1) : del_y;
        az  = del_z[31] ? (~del_z + 32'd1) : del_z;
        adc = diffusion_coefficient[31] ? (~diffusion_coefficient + 32'd1)
                                        : diffusion_coefficient;
        de  = {energy_i[31], energy_i} - {energy_j[31], energy_j};
        ade = de[32] ? (~de + 33'd1) : de;
    end

    always_ff @(posedge clk)
    begin
        sqx_reg  <= 64'(ax) * 64'(ax);
        sqy_reg  <= 64'(ay) * 64'(ay);
        sqz_reg  <= 64'(az) * 64'(az);
        hsq_reg  <= 62'(smoothing_length) * 62'(smoothing_length);
        pm_reg   <= 62'(mass_i) * 62'(mass_j);
        pr_reg   <= 62'(density_i) * 62'(density_j);
        sm_reg   <= 32'(mass_i) + 32'(mass_j);
        sr_reg   <= 32'(density_i) + 32'(density_j);
        adc_reg  <= adc;
        ade_reg  <= ade;
        h1_reg   <= smoothing_length;
        zf1_reg  <= (mass_i == '0) || (mass_j == '0) || (density_i == '0)
                 || (density_j == '0) || (diffusion_coefficient == '0) || (de == '0);
        neg1_reg <= 1'b1 ^ diffusion_coefficient[31] ^ de[32];
        upd1_reg <= newton_reg || j_is_local;
    end

    // stage 2: cutoff test and leading-zero counts
    assign rsq_sum = sqx_reg + sqy_reg + sqz_reg;

    always_ff @(posedge clk)
    begin
        rsq2_reg    <= rsq_sum;
        within2_reg <= rsq_sum < {2'b00, hsq_reg};
        zf2_reg     <= zf1_reg;
        neg2_reg    <= neg1_reg;
        upd2_reg    <= upd1_reg;
        pm2_reg     <= pm_reg;
        pr2_reg     <= pr_reg;
        sm2_reg     <= sm_reg;
        sr2_reg     <= sr_reg;
        adc2_reg    <= adc_reg;
        ade2_reg    <= ade_reg;
        h2_reg      <= h1_reg;
        lzpm_reg    <= lzc64(64'(pm_reg));
        lzpr_reg    <= lzc64(64'(pr_reg));
        lzsm_reg    <= lzc64(64'(sm_reg));
        lzsr_reg    <= lzc64(64'(sr_reg));
        lzdc_reg    <= lzc64(64'(adc_reg));
        lzde_reg    <= lzc64(64'(ade_reg));
        lzh_reg     <= lzc64(64'(h1_reg));
    end

    // stage 3: normalize
    always_ff @(posedge clk)
    begin
        rsq3_reg        <= rsq2_reg;
        h3_reg          <= h2_reg;
        mnum3_reg       <= mf_from(64'(pm2_reg), lzpm_reg, E_Q32);
        mden3_reg       <= mf_from(64'(sm2_reg), lzsm_reg, E_Q16);
        dnum3_reg       <= mf_from(64'(sr2_reg), lzsr_reg, E_Q16);
        dden3_reg       <= mf_from(64'(pr2_reg), lzpr_reg, E_Q32);
        dcf3_reg        <= mf_from(64'(adc2_reg), lzdc_reg, E_Q16);
        def3_reg        <= mf_from(64'(ade2_reg), lzde_reg, E_Q16);
        hf3_reg         <= mf_from(64'(h2_reg), lzh_reg, E_Q16);
        ctl3_reg.in_cut <= within2_reg;
        ctl3_reg.zero   <= zf2_reg;
        ctl3_reg.neg    <= neg2_reg;
        ctl3_reg.upd    <= within2_reg && upd2_reg;
    end

    // square root, one result bit per stage
    for (genvar gi = 0; gi < 32; gi++)
    begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
        logic [63:0] x_in, r_in, trial;
        if (gi == 0)
        begin : g_first
            assign x_in = rsq3_reg;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign x_in = root_x_reg[gi-1];
            assign r_in = root_r_reg[gi-1];
        end
        assign trial = r_in + BIT;
        always_ff @(posedge clk)
        begin
            if (x_in >= trial)
            begin
                root_x_reg[gi] <= x_in - trial;
                root_r_reg[gi] <= (r_in >> 1) + BIT;
            end
            else
            begin
                root_x_reg[gi] <= x_in;
                root_r_reg[gi] <= r_in >> 1;
            end
        end
    end

    assign dist_d = hdly_reg[31] - root_r_reg[31][30:0];
    assign cst.m  = three_dim_reg ? C3D_SIG : C2D_SIG;
    assign cst.e  = C_EXP;

    always_ff @(posedge clk)
    begin
        hdly_reg[0] <= h3_reg;
        for (int i = 1; i < 32; i++)
        begin
            hdly_reg[i] <= hdly_reg[i-1];
        end
        d36_reg   <= dist_d;
        lzd36_reg <= lzc64(64'(dist_d));
        df37_reg  <= mf_from(64'(d36_reg), lzd36_reg, E_Q16);
        df38_reg  <= df37_reg;
        t38_reg   <= mf_mul(cst, df37_reg);
        t39_reg   <= mf_mul(t38_reg, df38_reg);
    end

    // h to the kernel power, one product per stage, but the last stage multiplies only in 3D
    always_ff @(posedge clk)
    begin
        hk_reg[0]  <= mf_mul(hf3_reg, hf3_reg);
        hfd_reg[0] <= hf3_reg;
        for (int i = 1; i < 5; i++)
        begin
            hk_reg[i]  <= mf_mul(hk_reg[i-1], hfd_reg[i-1]);
            hfd_reg[i] <= hfd_reg[i-1];
        end
        hk_reg[5]  <= three_dim_reg ? mf_mul(hk_reg[4], hfd_reg[4]) : hk_reg[4];
        hkd_reg[0] <= hk_reg[5];
        for (int i = 1; i < 30; i++)
        begin
            hkd_reg[i] <= hkd_reg[i-1];
        end
    end

    shc_div u_div_mass (
        .clk (clk),
        .num (mnum3_reg.m),
        .den (mden3_reg.m),
        .quo (qm)
    );

    shc_div u_div_dens (
        .clk (clk),
        .num (dnum3_reg.m),
        .den (dden3_reg.m),
        .quo (qd)
    );

    shc_div u_div_kern (
        .clk (clk),
        .num (t39_reg.m),
        .den (hkd_reg[29].m),
        .quo (qw)
    );

    always_ff @(posedge clk)
    begin
        emd_reg[0]  <= mnum3_reg.e - EXP_W'(32) - mden3_reg.e;
        edd_reg[0]  <= dnum3_reg.e - EXP_W'(32) - dden3_reg.e;
        ewd_reg[0]  <= t39_reg.e - EXP_W'(32) - hkd_reg[29].e;
        vd_reg[0]   <= v39_reg;
        for (int i = 1; i < 33; i++)
        begin
            emd_reg[i] <= emd_reg[i-1];
            edd_reg[i] <= edd_reg[i-1];
            ewd_reg[i] <= ewd_reg[i-1];
            vd_reg[i]  <= vd_reg[i-1];
        end
        dcfd_reg[0] <= dcf3_reg;
        for (int i = 1; i < 34; i++)
        begin
            dcfd_reg[i] <= dcfd_reg[i-1];
        end
        defd_reg[0] <= def3_reg;
        for (int i = 1; i < 35; i++)
        begin
            defd_reg[i] <= defd_reg[i-1];
        end
        ctld_reg[0] <= ctl3_reg;
        for (int i = 1; i < 70; i++)
        begin
            ctld_reg[i] <= ctld_reg[i-1];
        end
        v37_reg <= mf_mul(mf_divn(qm, emd_reg[32]), mf_divn(qd, edd_reg[32]));
        v38_reg <= mf_mul(v37_reg, dcfd_reg[33]);
        v39_reg <= mf_mul(v38_reg, defd_reg[34]);
        v73_reg <= mf_mul(vd_reg[32], mf_divn(qw, ewd_reg[32]));
    end

    // scale to Q16.16 with the factor two, saturate
    always_comb
    begin
        s_exp = {v73_reg.e[EXP_W-1], v73_reg.e} + (EXP_W+1)'(17);
        s_neg = -s_exp;
        if (s_exp > 0)
        begin
            mag = 33'h1_0000_0000;
        end
        else if (s_exp <= -32)
        begin
            mag = '0;
        end
        else
        begin
            mag = 33'(v73_reg.m >> s_neg[4:0]);
        end
        if (ctld_reg[69].neg)
        begin
            if (mag > 33'h0_8000_0000)
            begin
                mag = 33'h0_8000_0000;
            end
            res = 32'(~mag + 33'd1);
        end
        else
        begin
            if (mag > 33'h0_7FFF_FFFF)
            begin
                mag = 33'h0_7FFF_FFFF;
            end
            res = mag[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        delta_energy_reg  <= (ctld_reg[69].in_cut && !ctld_reg[69].zero) ? res : '0;
        within_cutoff_reg <= ctld_reg[69].in_cut;
        update_j_reg      <= ctld_reg[69].upd;
    end

endmodule

>>> src/shc_div.sv
`timescale 1ns / 1ps
module shc_div (
    input  logic        clk,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [32:0] quo
);
    import shc_pkg::*;

    logic [31:0] rem_reg [33];
    logic [32:0] quo_reg [33];
    logic [31:0] den_reg [32];

    always_ff @(posedge clk)
    begin
        if (num >= den)
        begin
            rem_reg[0] <= num - den;
            quo_reg[0] <= 33'd1;
        end
        else
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= 33'd0;
        end
        den_reg[0] <= den;
    end

    for (genvar gi = 1; gi < 33; gi++)
    begin : g_step
        logic [32:0] sh;
        logic        ge;
        assign sh = {rem_reg[gi-1], 1'b0};
        assign ge = sh >= {1'b0, den_reg[gi-1]};
        always_ff @(posedge clk)
        begin
            rem_reg[gi] <= ge ? 32'(sh - {1'b0, den_reg[gi-1]}) : sh[31:0];
            quo_reg[gi] <= {quo_reg[gi-1][31:0], ge};
        end
        if (gi < 32)
        begin : g_den
            always_ff @(posedge clk)
            begin
                den_reg[gi] <= den_reg[gi-1];
            end
        end
    end

    assign quo = quo_reg[32];

endmodule

>>> src/shc_chk.sv
`timescale 1ns / 1ps
module shc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] delta_energy,
    input logic        within_cutoff,
    input logic        update_j
);
    import shc_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item result missing after fixed latency");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !within_cutoff) |-> (delta_energy == 32'd0 && !update_j))
        else $error("result outside cutoff not cleared");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

    a_busy_free: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised outside reset");

endmodule

bind sph_heat_conduction_pair shc_chk u_shc_chk (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import shc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic start;
    logic busy;
    logic signed [31:0] del_x, del_y, del_z;
    logic [30:0] mass_i, mass_j, density_i, density_j;
    logic signed [31:0] energy_i, energy_j;
    logic [30:0] smoothing_length;
    logic signed [31:0] diffusion_coefficient;
    logic j_is_local;
    logic done;
    logic signed [31:0] delta_energy;
    logic within_cutoff;
    logic update_j;

    typedef struct {
        logic [31:0] m;
        int          e;
    } flt_t;

    typedef struct {
        logic [31:0] delta;
        logic        in_cut;
        logic        upd;
    } pair_result_t;

    pair_result_t expected_pairs[$];
    logic kernel_3d;
    logic newton_on;
    int   error_count;
    int   idle_cycles;
    logic quiet_stretch;

    sph_heat_conduction_pair dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic flt_t norm(input logic [63:0] v, input int e);
        flt_t r;
        r.m = 0;
        r.e = 0;
        if (v == 0)
            return r;
        while (v >= 64'h1_0000_0000)
        begin
            v = v >> 1;
            e++;
        end
        while (v < 64'h8000_0000)
        begin
            v = v << 1;
            e--;
        end
        r.m = v[31:0];
        r.e = e;
        return r;
    endfunction

    function automatic flt_t fmul(input flt_t a, input flt_t b);
        if (a.m == 0 || b.m == 0)
            return norm(0, 0);
        return norm(64'(a.m) * 64'(b.m), a.e + b.e);
    endfunction

    function automatic flt_t fdiv(input flt_t a, input flt_t b);
        if (a.m == 0 || b.m == 0)
            return norm(0, 0);
        return norm({a.m, 32'd0} / 64'(b.m), a.e - 32 - b.e);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] absv(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic pair_result_t predict_heat_flow(
        input logic signed [31:0] dx, input logic signed [31:0] dy,
        input logic signed [31:0] dz, input logic [30:0] mi, input logic [30:0] mj,
        input logic [30:0] ri, input logic [30:0] rj, input logic signed [31:0] ei,
        input logic signed [31:0] ej, input logic [30:0] h,
        input logic signed [31:0] dc, input logic loc);
        pair_result_t r;
        logic [63:0] ax, ay, az, rsq, hh, mag, d;
        longint de;
        flt_t c, hf, hk, w, v;
        int k, s;
        logic neg;
        ax = absv(longint'(dx));
        ay = absv(longint'(dy));
        az = absv(longint'(dz));
        rsq = ax * ax + ay * ay + az * az;
        hh = 64'(h) * 64'(h);
        de = longint'(ei) - longint'(ej);
        r.in_cut = rsq < hh;
        r.upd = r.in_cut && (newton_on || loc);
        r.delta = 0;
        if (r.in_cut && ri != 0 && rj != 0)
        begin
            d = 64'(h) - root64(rsq);
            c.m = kernel_3d ? C3D_SIG : C2D_SIG;
            c.e = -27;
            k = kernel_3d ? 7 : 6;
            hf = norm(64'(h), -16);
            hk = hf;
            for (int n = 1; n < k; n++)
                hk = fmul(hk, hf);
            w = fdiv(fmul(fmul(c, norm(d, -16)), norm(d, -16)), hk);
            v = fdiv(norm(64'(mi) * 64'(mj), -32), norm(64'(mi) + 64'(mj), -16));
            v = fmul(v, fdiv(norm(64'(ri) + 64'(rj), -16),
                             norm(64'(ri) * 64'(rj), -32)));
            v = fmul(v, norm(absv(longint'(dc)), -16));
            v = fmul(v, norm(absv(de), -16));
            v = fmul(v, w);
            if (v.m != 0)
                v.e++;
            neg = 1'b1 ^ (dc < 0) ^ (de < 0);
            if (v.m != 0)
            begin
                s = v.e + 16;
                if (s > 0)
                    mag = 64'h1_0000_0000;
                else if (s <= -32)
                    mag = 0;
                else
                    mag = 64'(v.m) >> (-s);
                if (neg)
                begin
                    if (mag > 64'h8000_0000)
                        mag = 64'h8000_0000;
                    r.delta = 32'(-mag);
                end
                else
                begin
                    if (mag > 64'h7FFF_FFFF)
                        mag = 64'h7FFF_FFFF;
                    r.delta = mag[31:0];
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        pair_result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_pairs.size() == 0)
            begin
                $error("unexpected result delta_energy=%h", delta_energy);
                error_count++;
            end
            else
            begin
                exp_r = expected_pairs.pop_front();
                if (delta_energy !== exp_r.delta)
                begin
                    $error("delta_energy expected %h actual %h", exp_r.delta, delta_energy);
                    error_count++;
                end
                if (within_cutoff !== exp_r.in_cut)
                begin
                    $error("within_cutoff expected %b actual %b", exp_r.in_cut,
                           within_cutoff);
                    error_count++;
                end
                if (update_j !== exp_r.upd)
                begin
                    $error("update_j expected %b actual %b", exp_r.upd, update_j);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drain();
        while (expected_pairs.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_THREE_DIM)
            kernel_3d = val[0];
        else if (idx == REG_NEWTON)
            newton_on = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(
        input logic signed [31:0] dx, input logic signed [31:0] dy,
        input logic signed [31:0] dz, input logic [30:0] mi, input logic [30:0] mj,
        input logic [30:0] ri, input logic [30:0] rj, input logic signed [31:0] ei,
        input logic signed [31:0] ej, input logic [30:0] h,
        input logic signed [31:0] dc, input logic loc);
        if (!quiet_stretch)
        begin
            while ($urandom_range(99) < 29)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        del_x <= dx;
        del_y <= dy;
        del_z <= dz;
        mass_i <= mi;
        mass_j <= mj;
        density_i <= ri;
        density_j <= rj;
        energy_i <= ei;
        energy_j <= ej;
        smoothing_length <= h;
        diffusion_coefficient <= dc;
        j_is_local <= loc;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_pairs.push_back(predict_heat_flow(dx, dy, dz, mi, mj, ri, rj, ei, ej,
                                                   h, dc, loc));
        @(negedge clk);
    endtask

    task automatic finish_items();
        start <= 1'b0;
        wait_drain();
    endtask

    task automatic send_random_pair(input int shape);
        logic [30:0] h;
        logic [31:0] sc;
        h = 31'($urandom);
        case (shape)
            0: h = 31'($urandom_range(32'h0004_0000, 32'h0001_0000));
            1: h = 31'($urandom_range(32'h0100_0000, 32'h0000_4000));
            default: ;
        endcase
        sc = shape == 2 ? 32'hFFFF_FFFF : 32'(h >> 1);
        send_pair($urandom & sc, $urandom & sc, $urandom & sc,
                  $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h40000, 1)),
                  31'($urandom), 31'($urandom),
                  $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h40000, 1)),
                  $urandom, $urandom, h, $urandom, $urandom_range(1));
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000,
                  32'h2_0000, 0, 31'h1_0000, 32'h1_0000, 1);
        send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 0);
        send_pair(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h1, 31'h1, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_pair(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h1, 31'h1, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 31'h1, 32'sh7FFF_FFFF, 1);
        send_pair(32'h1_0000, 0, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000,
                  32'h1_0000, 0, 31'h1_0000, 32'h1_0000, 1);
        send_pair(0, 0, 32'h8000, 31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000,
                  32'h1_0000, 0, 31'h1_0000, 32'h1_0000, 1);
        send_pair(0, 0, 32'h8000, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000,
                  32'h1_0000, 0, 31'h1_0000, 32'h1_0000, 1);
        send_pair(0, 32'h100, 0, 31'h1_0000, 31'h1_0000, 0, 31'h1_0000,
                  32'h1_0000, 0, 31'h1_0000, 32'h1_0000, 1);
        send_pair(0, 32'h100, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000, 0,
                  32'h1_0000, 0, 31'h1_0000, 32'h1_0000, 0);
        send_pair(0, 0, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000,
                  32'h1_0000, 0, 0, 32'h1_0000, 1);
        send_pair(32'sh1000, 32'shFFFF_F000, 32'sh1000, 31'h3_0000, 31'h5_0000,
                  31'h2_0000, 31'h1_8000, 32'shFFFF_0000, 32'h3_0000, 31'h2_0000,
                  32'shFFFE_0000, 0);
        send_pair(32'sh100, 0, 0, 31'h1, 31'h1, 31'h1, 31'h1, 32'h10, 0, 31'h200,
                  32'h1, 1);
        finish_items();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            quiet_stretch = (n >= count / 2) && (n < count / 2 + 120);
            send_random_pair($urandom_range(3) == 3 ? 2 : $urandom_range(1));
        end
        quiet_stretch = 1'b0;
        finish_items();
    endtask

    task automatic test_settings();
        write_reg(REG_THREE_DIM, 32'h0);
        write_reg(REG_NEWTON, 32'hFFFF_FFFF);
        test_directed();
        test_random(400);
        write_reg(REG_NEWTON, 32'hFFFF_FFFE);
        test_random(400);
        write_reg(REG_THREE_DIM, 32'hFFFF_FFFF);
        write_reg(REG_NEWTON, 32'h1);
        test_directed();
        test_random(400);
        write_reg(8'hFF, 32'h0);
        write_reg(8'd2, 32'h0);
        test_random(200);
    endtask

    initial
    begin
        error_count = 0;
        quiet_stretch = 1'b0;
        kernel_3d = 1'b1;
        newton_on = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        del_x = 0;
        del_y = 0;
        del_z = 0;
        mass_i = 0;
        mass_j = 0;
        density_i = 0;
        density_j = 0;
        energy_i = 0;
        energy_j = 0;
        smoothing_length = 0;
        diffusion_coefficient = 0;
        j_is_local = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(200);
        test_settings();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
